// File: rtl/cmp_pkg.sv
// Shared constants, command and status types for the constrained motion planner.
`timescale 1ns / 1ps
package cmp_pkg;

    localparam int VW   = 32;   // value width
    localparam int FB   = 16;   // fraction bits of values
    localparam int DTF  = 24;   // fraction bits of the time step
    localparam int MW   = 34;   // multiplier operand width
    localparam int PW   = 2 * MW;
    localparam int SUMW = 88;   // tracking accumulator width
    localparam int DIVN = 66;   // dividend and quotient width
    localparam int DIVD = 34;   // divisor width

    // divide by ten as a multiply by ceil(2^35 / 10) and a shift by 35
    localparam logic [31:0] RECIP10    = 32'hCCCC_CCCD;
    localparam int          RECIP10_SH = 35;

    localparam logic [30:0] AMAX_RST = 31'd1310720;
    localparam logic [30:0] VMAX_RST = 31'd655360;
    localparam logic [23:0] WN_RST   = 24'd1310720;
    localparam logic [23:0] DT_RST   = 24'd16777;

    // configuration register indexes
    localparam logic [1:0] CFG_AMAX = 2'd0;
    localparam logic [1:0] CFG_VMAX = 2'd1;
    localparam logic [1:0] CFG_WN   = 2'd2;
    localparam logic [1:0] CFG_DT   = 2'd3;

    // branch codes
    localparam logic [1:0] BR_TRACK = 2'd0;
    localparam logic [1:0] BR_BRAKE = 2'd1;
    localparam logic [1:0] BR_REV   = 2'd2;
    localparam logic [1:0] BR_LOAD  = 2'd3;

    // input opcode
    localparam logic OPC_LOAD = 1'b0;

    typedef logic [4:0] t_op;

    localparam t_op OP_NONE = 5'd0;
    localparam t_op OP_LOAD = 5'd1;
    localparam t_op OP_PREP = 5'd2;
    localparam t_op OP_M1   = 5'd3;
    localparam t_op OP_M2   = 5'd4;
    localparam t_op OP_M3   = 5'd5;
    localparam t_op OP_M4   = 5'd6;
    localparam t_op OP_M5   = 5'd7;
    localparam t_op OP_DEC  = 5'd8;
    localparam t_op OP_BRK  = 5'd9;
    localparam t_op OP_BRKA = 5'd10;
    localparam t_op OP_REV  = 5'd11;
    localparam t_op OP_T0   = 5'd12;
    localparam t_op OP_T1   = 5'd13;
    localparam t_op OP_T2   = 5'd14;
    localparam t_op OP_T3   = 5'd15;
    localparam t_op OP_T4   = 5'd16;
    localparam t_op OP_TRKA = 5'd17;
    localparam t_op OP_V1   = 5'd18;
    localparam t_op OP_V2   = 5'd19;
    localparam t_op OP_V3   = 5'd20;
    localparam t_op OP_V4   = 5'd21;
    localparam t_op OP_ACC  = 5'd22;
    localparam t_op OP_FIN  = 5'd23;

    typedef struct packed {
        logic capture;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic       div_done;
        logic [1:0] branch;
        logic       dt_zero;
        logic       out_busy;
    } t_sts;

endpackage

// File: rtl/cmp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module cmp_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cmp_pkg::DIVN-1:0]    i_dividend,
    input  logic [cmp_pkg::DIVD-1:0]    i_divisor,
    output logic [cmp_pkg::DIVN-1:0]    o_quotient,
    output logic                        o_done
);
    import cmp_pkg::*;

    localparam logic [6:0] STEPS = 7'(DIVN);

    logic            r_busy;
    logic            r_done;
    logic [6:0]      r_cnt;
    logic [DIVD-1:0] r_rem;
    logic [DIVD-1:0] r_d;
    logic [DIVN-1:0] r_quo;
    logic [DIVD:0]   w_trial;
    logic [DIVD:0]   w_sub;
    logic            w_ge;

    // shift in the next dividend bit and try the subtract
    assign w_trial = {r_rem, r_quo[DIVN-1]};
    assign w_sub   = w_trial - {1'b0, r_d};
    assign w_ge    = w_trial >= {1'b0, r_d};

    // sequence control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_d   <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_sub[DIVD-1:0] : w_trial[DIVD-1:0];
            r_quo <= {r_quo[DIVN-2:0], w_ge};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// File: rtl/cmp_dp.sv
// Datapath: configuration, axis state, shared multiplier, divider and result register.
`timescale 1ns / 1ps
module cmp_dp (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cmp_pkg::t_cmd        i_cmd,
    output cmp_pkg::t_sts        o_sts,
    input  logic [159:0]         i_s_tdata,
    input  logic                 i_s_opcode,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [95:0]          o_m_tdata,
    output logic [3:0]           o_m_tuser
);
    import cmp_pkg::*;

    // configuration registers
    logic [30:0] r_amax, r_vmax;
    logic [23:0] r_wn, r_dt;

    // axis state and request operands
    logic signed [31:0] r_th, r_v, r_acc;
    logic signed [31:0] r_tp, r_tv, r_ta;

    // working registers
    logic signed [32:0]   r_e, r_ve, r_diff;
    logic signed [PW-1:0] r_prod, r_num;
    logic [PW-1:0]        r_lhs;
    logic                 r_close;
    logic [1:0]           r_branch;
    logic [47:0]          r_wn2;
    logic signed [SUMW-1:0] r_sum;
    logic signed [31:0]   r_a, r_vn;
    logic                 r_aclip, r_vclip;
    logic signed [33:0]   r_thr;

    // result register
    logic        r_ovalid;
    logic [95:0] r_odata;
    logic [3:0]  r_ouser;

    logic signed [MW-1:0] w_ma, w_mb;
    logic signed [PW-1:0] w_prod;
    logic [32:0]          w_ae, w_ave, w_adiff;
    logic [31:0]          w_atv;
    logic signed [32:0]   w_diff;
    logic [PW-1:0]        w_nmag;
    logic                 w_div_start;
    logic [DIVN-1:0]      w_dividend, w_quo;
    logic [DIVD-1:0]      w_divisor;
    logic                 w_div_done;
    logic signed [33:0]   w_thr, w_v34;
    logic                 w_e_pos, w_e_neg, w_ve_pos, w_ve_neg, w_approach, w_wrong;
    logic signed [55:0]   w_des, w_amax56;
    logic signed [44:0]   w_vsum, w_asum, w_vmax45;
    logic [30:0]          w_bmag;
    logic                 w_rneg;

    // magnitudes of signed quantities
    assign w_ae    = r_e[32] ? (~r_e + 33'd1) : r_e;
    assign w_ave   = r_ve[32] ? (~r_ve + 33'd1) : r_ve;
    assign w_atv   = r_tv[31] ? (~r_tv + 32'd1) : r_tv;
    assign w_diff  = {r_vn[31], r_vn} - {r_v[31], r_v};
    assign w_adiff = w_diff[32] ? (~w_diff + 33'd1) : w_diff;
    assign w_nmag  = r_num[PW-1] ? (~r_num + 1'b1) : r_num;

    // select multiplier operands for the current step
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_PREP: begin
                w_ma = {2'b0, w_atv};
                w_mb = {2'b0, RECIP10};
            end
            OP_M1: begin
                w_ma = {2'b0, r_amax, 1'b0};
                w_mb = {1'b0, w_ae};
            end
            OP_M2: begin
                w_ma = {1'b0, w_ave};
                w_mb = {1'b0, w_ave};
            end
            OP_M3: begin
                w_ma = {{2{r_tv[31]}}, r_tv};
                w_mb = {{2{r_tv[31]}}, r_tv};
            end
            OP_M4: begin
                w_ma = {{2{r_v[31]}}, r_v};
                w_mb = {{2{r_v[31]}}, r_v};
            end
            OP_T0: begin
                w_ma = {10'b0, r_wn};
                w_mb = {10'b0, r_wn};
            end
            OP_T1: begin
                w_ma = {10'b0, r_wn};
                w_mb = {r_ve[32], r_ve};
            end
            OP_T2: begin
                w_ma = {r_e[32], r_e};
                w_mb = {10'b0, r_wn2[23:0]};
            end
            OP_T3: begin
                w_ma = {r_e[32], r_e};
                w_mb = {10'b0, r_wn2[47:24]};
            end
            OP_V1: begin
                w_ma = {{2{r_a[31]}}, r_a};
                w_mb = {10'b0, r_dt};
            end
            OP_V3: begin
                w_ma = {{2{r_vn[31]}}, r_vn};
                w_mb = {10'b0, r_dt};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    assign w_prod = w_ma * w_mb;

    // divider requests: braking quotient, applied acceleration
    always_comb begin
        w_div_start = 1'b0;
        w_dividend  = '0;
        w_divisor   = '0;
        case (i_cmd.op)
            OP_BRK: begin
                w_div_start = 1'b1;
                w_dividend  = w_nmag[DIVN-1:0];
                w_divisor   = {w_ae, 1'b0};
            end
            OP_V3: begin
                w_div_start = (r_dt != '0);
                w_dividend  = {9'b0, w_adiff, 24'b0};
                w_divisor   = {10'b0, r_dt};
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    cmp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // branch decision terms
    assign w_thr      = r_thr;
    assign w_v34      = {{2{r_v[31]}}, r_v};
    assign w_e_pos    = !r_e[32] && (r_e != '0);
    assign w_e_neg    = r_e[32];
    assign w_ve_pos   = !r_ve[32] && (r_ve != '0);
    assign w_ve_neg   = r_ve[32];
    assign w_approach = (w_e_pos && w_ve_pos) || (w_e_neg && w_ve_neg);
    assign w_wrong    = (!w_e_neg && (w_v34 < -w_thr)) || (w_e_neg && (w_v34 > w_thr));

    // clamp inputs
    assign w_des    = r_sum[SUMW-1:32];
    assign w_amax56 = {25'b0, r_amax};
    assign w_vmax45 = {14'b0, r_vmax};
    assign w_vsum   = {r_prod[PW-1], r_prod[PW-1:24]} + {{13{r_v[31]}}, r_v};
    assign w_asum   = {r_prod[PW-1], r_prod[PW-1:24]} + {{13{r_th[31]}}, r_th};
    assign w_rneg   = r_num[PW-1] ^ r_e[32];
    assign w_bmag   = (w_quo > {35'b0, r_amax}) ? r_amax : w_quo[30:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_amax <= AMAX_RST;
            r_vmax <= VMAX_RST;
            r_wn   <= WN_RST;
            r_dt   <= DT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_AMAX: r_amax <= i_cfg_data[30:0];
                CFG_VMAX: r_vmax <= i_cfg_data[30:0];
                CFG_WN:   r_wn   <= i_cfg_data[23:0];
                CFG_DT:   r_dt   <= i_cfg_data[23:0];
                default:  r_amax <= r_amax;
            endcase
        end
    end

    // capture the request operands
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tp <= (i_s_opcode == OPC_LOAD) ? i_s_tdata[127:96] : i_s_tdata[31:0];
            r_tv <= (i_s_opcode == OPC_LOAD) ? i_s_tdata[159:128] : i_s_tdata[63:32];
            r_ta <= i_s_tdata[95:64];
        end
    end

    // axis state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_th  <= '0;
            r_v   <= '0;
            r_acc <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    r_th  <= r_tp;
                    r_v   <= r_tv;
                    r_acc <= '0;
                end
                OP_V4: begin
                    if (w_asum > 45'sd2147483647)
                        r_th <= 32'sh7fffffff;
                    else if (w_asum < -45'sd2147483648)
                        r_th <= 32'sh80000000;
                    else
                        r_th <= w_asum[31:0];
                end
                OP_ACC: begin
                    r_v <= r_vn;
                    if (r_dt == '0)
                        r_acc <= '0;
                    else if (r_diff[32])
                        r_acc <= (w_quo > 66'd2147483648) ? 32'sh80000000
                                                          : (~w_quo[31:0] + 32'd1);
                    else
                        r_acc <= (w_quo > 66'd2147483647) ? 32'sh7fffffff : w_quo[31:0];
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

    // working registers, one step at a time
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (i_cmd.op)
            OP_LOAD: begin
                r_branch <= BR_LOAD;
                r_aclip  <= 1'b0;
                r_vclip  <= 1'b0;
            end
            OP_PREP: begin
                r_e  <= {r_tp[31], r_tp} - {r_th[31], r_th};
                r_ve <= {r_v[31], r_v} - {r_tv[31], r_tv};
            end
            // velocity threshold: a tenth of the target speed plus one
            OP_M1: r_thr   <= {2'b0, r_prod[RECIP10_SH+31:RECIP10_SH]} + 34'd65536;
            OP_M2: r_lhs   <= r_prod;
            OP_M3: r_close <= (r_lhs <= $unsigned(r_prod));
            OP_M4: r_num   <= r_prod;
            OP_M5: r_num   <= r_num - r_prod;
            OP_DEC: begin
                if (w_approach && r_close)
                    r_branch <= BR_BRAKE;
                else if (w_wrong)
                    r_branch <= BR_REV;
                else
                    r_branch <= BR_TRACK;
            end
            OP_BRKA: begin
                r_aclip <= (w_quo > {35'b0, r_amax});
                r_a     <= w_rneg ? -$signed({1'b0, w_bmag}) : $signed({1'b0, w_bmag});
            end
            OP_REV: begin
                r_aclip <= 1'b0;
                r_a     <= (!r_v[31] && (r_v != '0)) ? -$signed({1'b0, r_amax})
                                                     : $signed({1'b0, r_amax});
            end
            OP_T1: r_wn2 <= r_prod[47:0];
            OP_T2: r_sum <= ({{(SUMW-32){r_ta[31]}}, r_ta} <<< 32)
                          - ({{(SUMW-PW){r_prod[PW-1]}}, r_prod} <<< 17);
            OP_T3: r_sum <= r_sum + {{(SUMW-PW){r_prod[PW-1]}}, r_prod};
            OP_T4: r_sum <= r_sum + ({{(SUMW-PW){r_prod[PW-1]}}, r_prod} <<< 24);
            OP_TRKA: begin
                if (w_des > w_amax56) begin
                    r_a     <= $signed({1'b0, r_amax});
                    r_aclip <= 1'b1;
                end else if (w_des < -w_amax56) begin
                    r_a     <= -$signed({1'b0, r_amax});
                    r_aclip <= 1'b1;
                end else begin
                    r_a     <= w_des[31:0];
                    r_aclip <= 1'b0;
                end
            end
            OP_V2: begin
                if (w_vsum > w_vmax45) begin
                    r_vn    <= $signed({1'b0, r_vmax});
                    r_vclip <= 1'b1;
                end else if (w_vsum < -w_vmax45) begin
                    r_vn    <= -$signed({1'b0, r_vmax});
                    r_vclip <= 1'b1;
                end else begin
                    r_vn    <= w_vsum[31:0];
                    r_vclip <= 1'b0;
                end
            end
            OP_V3: r_diff <= w_diff;
            default: r_close <= r_close;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_FIN) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FIN) begin
            r_odata <= {r_acc, r_v, r_th};
            r_ouser <= {r_vclip, r_aclip, r_branch};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;

    assign o_sts.div_done = w_div_done;
    assign o_sts.branch   = r_branch;
    assign o_sts.dt_zero  = (r_dt == '0);
    assign o_sts.out_busy = r_ovalid && !i_m_tready;

endmodule

// File: rtl/cmp_ctrl.sv
// Controller: sequences the datapath through load and planning steps.
`timescale 1ns / 1ps
module cmp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_s_opcode,
    output logic           o_s_tready,
    input  cmp_pkg::t_sts  i_sts,
    output cmp_pkg::t_cmd  o_cmd
);
    import cmp_pkg::*;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_LOAD = 5'd1;
    localparam logic [4:0] S_PREP = 5'd2;
    localparam logic [4:0] S_M1   = 5'd3;
    localparam logic [4:0] S_M2   = 5'd4;
    localparam logic [4:0] S_M3   = 5'd5;
    localparam logic [4:0] S_M4   = 5'd6;
    localparam logic [4:0] S_M5   = 5'd7;
    localparam logic [4:0] S_DEC  = 5'd9;
    localparam logic [4:0] S_SEL  = 5'd10;
    localparam logic [4:0] S_BRK  = 5'd11;
    localparam logic [4:0] S_WBRK = 5'd12;
    localparam logic [4:0] S_BRKA = 5'd13;
    localparam logic [4:0] S_REV  = 5'd14;
    localparam logic [4:0] S_T0   = 5'd15;
    localparam logic [4:0] S_T1   = 5'd16;
    localparam logic [4:0] S_T2   = 5'd17;
    localparam logic [4:0] S_T3   = 5'd18;
    localparam logic [4:0] S_T4   = 5'd19;
    localparam logic [4:0] S_TRKA = 5'd20;
    localparam logic [4:0] S_V1   = 5'd21;
    localparam logic [4:0] S_V2   = 5'd22;
    localparam logic [4:0] S_V3   = 5'd23;
    localparam logic [4:0] S_V4   = 5'd24;
    localparam logic [4:0] S_WACC = 5'd25;
    localparam logic [4:0] S_ACC  = 5'd26;
    localparam logic [4:0] S_FIN  = 5'd27;

    logic [4:0] r_state, n_state;
    logic       w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept)
                    n_state = (i_s_opcode == OPC_LOAD) ? S_LOAD : S_PREP;
            end
            S_LOAD: n_state = S_FIN;
            S_PREP: n_state = S_M1;
            S_M1:   n_state = S_M2;
            S_M2:   n_state = S_M3;
            S_M3:   n_state = S_M4;
            S_M4:   n_state = S_M5;
            S_M5:   n_state = S_DEC;
            S_DEC:  n_state = S_SEL;
            S_SEL: begin
                case (i_sts.branch)
                    BR_BRAKE: n_state = S_BRK;
                    BR_REV:   n_state = S_REV;
                    default:  n_state = S_T0;
                endcase
            end
            S_BRK:  n_state = S_WBRK;
            S_WBRK: if (i_sts.div_done) n_state = S_BRKA;
            S_BRKA: n_state = S_V1;
            S_REV:  n_state = S_V1;
            S_T0:   n_state = S_T1;
            S_T1:   n_state = S_T2;
            S_T2:   n_state = S_T3;
            S_T3:   n_state = S_T4;
            S_T4:   n_state = S_TRKA;
            S_TRKA: n_state = S_V1;
            S_V1:   n_state = S_V2;
            S_V2:   n_state = S_V3;
            S_V3:   n_state = S_V4;
            S_V4:   n_state = i_sts.dt_zero ? S_ACC : S_WACC;
            S_WACC: if (i_sts.div_done) n_state = S_ACC;
            S_ACC:  n_state = S_FIN;
            S_FIN:  if (!i_sts.out_busy) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath step for each state
    always_comb begin
        o_cmd.capture = w_accept;
        case (r_state)
            S_LOAD: o_cmd.op = OP_LOAD;
            S_PREP: o_cmd.op = OP_PREP;
            S_M1:   o_cmd.op = OP_M1;
            S_M2:   o_cmd.op = OP_M2;
            S_M3:   o_cmd.op = OP_M3;
            S_M4:   o_cmd.op = OP_M4;
            S_M5:   o_cmd.op = OP_M5;
            S_DEC:  o_cmd.op = OP_DEC;
            S_BRK:  o_cmd.op = OP_BRK;
            S_BRKA: o_cmd.op = OP_BRKA;
            S_REV:  o_cmd.op = OP_REV;
            S_T0:   o_cmd.op = OP_T0;
            S_T1:   o_cmd.op = OP_T1;
            S_T2:   o_cmd.op = OP_T2;
            S_T3:   o_cmd.op = OP_T3;
            S_T4:   o_cmd.op = OP_T4;
            S_TRKA: o_cmd.op = OP_TRKA;
            S_V1:   o_cmd.op = OP_V1;
            S_V2:   o_cmd.op = OP_V2;
            S_V3:   o_cmd.op = OP_V3;
            S_V4:   o_cmd.op = OP_V4;
            S_ACC:  o_cmd.op = OP_ACC;
            S_FIN:  o_cmd.op = i_sts.out_busy ? OP_NONE : OP_FIN;
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// File: rtl/constrained_motion_planner.sv
// Top level of the constrained motion planner: controller, datapath and ports.
// A planning request runs the shared divider once, or twice when braking; with a zero time
// step it runs one time fewer. A load goes straight to the result without a divide.
// Throughput: one request at a time; the next is taken the cycle after its result is staged.
// Reset: synchronous, active low; clears the axis state and loads the register defaults.
`timescale 1ns / 1ps
module constrained_motion_planner (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // target_position, target_velocity, target_acceleration, load_angle, load_velocity
    input  logic [159:0]  s_axis_tdata,
    // opcode
    input  logic [0:0]    s_axis_tuser,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // commanded_angle, commanded_velocity, commanded_acceleration
    output logic [95:0]   m_axis_tdata,
    // branch_taken[1:0], accel_clamped, velocity_clamped
    output logic [3:0]    m_axis_tuser,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import cmp_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    cmp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_opcode (s_axis_tuser[0]),
        .o_s_tready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    cmp_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_s_tdata   (s_axis_tdata),
        .i_s_opcode  (s_axis_tuser[0]),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata),
        .o_m_tuser   (m_axis_tuser)
    );

endmodule

// File: dv/cmp_checker.sv
// Checker for the motion planner: watches the streams, predicts each result and compares.
`timescale 1ns / 1ps
module cmp_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    input  logic          i_s_ready,
    input  logic [159:0]  i_s_data,
    input  logic [0:0]    i_s_user,
    input  logic          i_m_valid,
    input  logic          i_m_ready,
    input  logic [95:0]   i_m_data,
    input  logic [3:0]    i_m_user,
    input  logic          i_cfg_valid,
    input  logic          i_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    output int            o_errors,
    output int            o_pending,
    output int            o_checked,
    output int            o_tracks,
    output int            o_brakes,
    output int            o_reversals
);
    import cmp_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic [31:0] angle;
        logic [31:0] velocity;
        logic [31:0] accel;
        logic [1:0]  branch;
        logic        aclip;
        logic        vclip;
    } t_motion;

    localparam t_wide VAL_HI = 128'sh7FFF_FFFF;
    localparam t_wide VAL_LO = -VAL_HI - 1;

    t_motion      expected_q[$];
    logic [30:0]  amax_reg, vmax_reg;
    logic [23:0]  wn_reg, dt_reg;
    logic [31:0]  angle_st, vel_st, acc_st;

    function automatic t_wide clampw(input t_wide x, input t_wide lo, input t_wide hi,
                                     output logic hit);
        hit = 1'b1;
        if (x < lo) return lo;
        if (x > hi) return hi;
        hit = 1'b0;
        return x;
    endfunction

    // Advance the axis state by one request and return the result it yields.
    function automatic t_motion plan_motion(input logic op, input logic [159:0] d);
        t_motion r;
        t_wide tp, tv, ta, th, v, e, ve, am, vm, wn, dt, ae, thr;
        t_wide num, nmag, den, q, des, a, vn, diff, ac;
        logic  approaching, near_stop, wrong, nneg, rneg, dummy;
        r = '0;
        if (op == OPC_LOAD) begin
            angle_st = d[127:96];
            vel_st   = d[159:128];
            acc_st   = '0;
            r.branch = BR_LOAD;
        end else begin
            tp = t_wide'($signed(d[31:0]));
            tv = t_wide'($signed(d[63:32]));
            ta = t_wide'($signed(d[95:64]));
            th = t_wide'($signed(angle_st));
            v  = t_wide'($signed(vel_st));
            am = {97'd0, amax_reg};
            vm = {97'd0, vmax_reg};
            wn = {104'd0, wn_reg};
            dt = {104'd0, dt_reg};
            e  = tp - th;
            ve = v - tv;
            ae = (e < 0) ? -e : e;
            approaching = (e > 0 && v > tv) || (e < 0 && v < tv);
            near_stop = (2 * am * ae) <= (ve * ve);
            thr = ((tv < 0) ? -tv : tv) / 10 + 65536;
            wrong = (e >= 0 && v < -thr) || (e < 0 && v > thr);
            if (approaching && near_stop) begin
                // brake so that the velocity reaches the target velocity at the target
                r.branch = BR_BRAKE;
                num  = tv * tv - v * v;
                nneg = num < 0;
                nmag = nneg ? -num : num;
                den  = 2 * ae;
                rneg = nneg != (e < 0);
                if (nmag >= (am + 1) * den) begin
                    des = rneg ? -(am + 1) : am + 1;
                end else begin
                    q   = nmag / den;
                    des = rneg ? -q : q;
                end
            end else if (wrong) begin
                r.branch = BR_REV;
                des = (v > 0) ? -am : am;
            end else begin
                r.branch = BR_TRACK;
                des = (wn * wn * e - ((2 * wn) <<< 16) * ve + (ta <<< 32)) >>> 32;
            end
            a  = clampw(des, -am, am, r.aclip);
            vn = clampw(((a * dt) >>> 24) + v, -vm, vm, r.vclip);
            if (dt == 0) begin
                ac = 0;
            end else begin
                diff = vn - v;
                q  = (((diff < 0) ? -diff : diff) <<< 24) / dt;
                ac = clampw((diff < 0) ? -q : q, VAL_LO, VAL_HI, dummy);
            end
            angle_st = 32'(clampw(((vn * dt) >>> 24) + th, VAL_LO, VAL_HI, dummy));
            vel_st   = 32'(vn);
            acc_st   = 32'(ac);
        end
        r.angle    = angle_st;
        r.velocity = vel_st;
        r.accel    = acc_st;
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("mismatch at result %0d: %s expected %h got %h", o_checked, field, want, got);
        o_errors++;
    endtask

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_motion want, got;
        if (!i_rst_n) begin
            amax_reg = AMAX_RST;
            vmax_reg = VMAX_RST;
            wn_reg   = WN_RST;
            dt_reg   = DT_RST;
            angle_st = '0;
            vel_st   = '0;
            acc_st   = '0;
            expected_q.delete();
            o_errors = 0; o_checked = 0;
            o_tracks = 0; o_brakes = 0; o_reversals = 0;
        end else begin
            // track register writes
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_AMAX: amax_reg = i_cfg_data[30:0];
                    CFG_VMAX: vmax_reg = i_cfg_data[30:0];
                    CFG_WN:   wn_reg   = i_cfg_data[23:0];
                    CFG_DT:   dt_reg   = i_cfg_data[23:0];
                    default: ;
                endcase
            end
            // compare the returned result with the oldest prediction
            if (i_m_valid && i_m_ready) begin
                got = {i_m_data[31:0], i_m_data[63:32], i_m_data[95:64],
                       i_m_user[1:0], i_m_user[2], i_m_user[3]};
                if (expected_q.size() == 0) begin
                    report("unexpected result", '0, i_m_data[31:0]);
                end else begin
                    want = expected_q.pop_front();
                    if (got.angle !== want.angle) report("angle", want.angle, got.angle);
                    if (got.velocity !== want.velocity)
                        report("velocity", want.velocity, got.velocity);
                    if (got.accel !== want.accel) report("accel", want.accel, got.accel);
                    if (got.branch !== want.branch)
                        report("branch", 32'(want.branch), 32'(got.branch));
                    if (got.aclip !== want.aclip)
                        report("accel_clamped", 32'(want.aclip), 32'(got.aclip));
                    if (got.vclip !== want.vclip)
                        report("velocity_clamped", 32'(want.vclip), 32'(got.vclip));
                    case (want.branch)
                        BR_TRACK: o_tracks++;
                        BR_BRAKE: o_brakes++;
                        BR_REV:   o_reversals++;
                        default: ;
                    endcase
                end
                o_checked++;
            end
            // predict each accepted request
            if (i_s_valid && i_s_ready)
                expected_q.push_back(plan_motion(i_s_user[0], i_s_data));
        end
    end

endmodule

// File: dv/tb_top.sv
// Testbench top for the motion planner: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps
module tb_top;
    import cmp_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_ITEMS = 1430;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          s_axis_tvalid = 1'b0;
    logic          s_axis_tready;
    logic [159:0]  s_axis_tdata = '0;
    logic [0:0]    s_axis_tuser = '0;
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [95:0]   m_axis_tdata;
    logic [3:0]    m_axis_tuser;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [1:0]    i_cfg_index = '0;
    logic [31:0]   i_cfg_data = '0;

    int  errors, pending, checked, tracks, brakes, reversals;
    int  cycles = 0;
    int  sent = 0;
    bit  calm = 0;        // no idling on either side
    int  hold_req = 0;    // receiver hold-off length requested by the stimulus

    constrained_motion_planner DUT (.*);

    cmp_checker u_checker (
        .i_clk, .i_rst_n,
        .i_s_valid(s_axis_tvalid), .i_s_ready(s_axis_tready),
        .i_s_data(s_axis_tdata), .i_s_user(s_axis_tuser),
        .i_m_valid(m_axis_tvalid), .i_m_ready(m_axis_tready),
        .i_m_data(m_axis_tdata), .i_m_user(m_axis_tuser),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_checked(checked),
        .o_tracks(tracks), .o_brakes(brakes), .o_reversals(reversals)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Drive the result ready: random stalls, plus a long hold-off on request.
    initial begin : receiver
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                hold = hold_req;
                hold_req = 0;
            end
            if (hold > 0) begin
                hold--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= calm || ($urandom_range(99) >= 38);
            end
        end
    end

    function automatic logic [31:0] pick_value();
        case ($urandom_range(4))
            0: return 32'($signed($urandom_range(131072)) - 65536);
            1: return {{8{1'($urandom_range(1))}}, 24'($urandom)};
            2: return $urandom;
            3: begin
                case ($urandom_range(4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'd1;
                    default: return 32'd0;
                endcase
            end
            default: return {{12{1'($urandom_range(1))}}, 20'($urandom)};
        endcase
    endfunction

    // Offer one request, with a random gap in front of it.
    task automatic send_item(input logic op, input logic [31:0] tp, input logic [31:0] tv,
                             input logic [31:0] ta, input logic [31:0] la,
                             input logic [31:0] lv);
        while (!calm && $urandom_range(99) < 38) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {lv, la, ta, tv, tp};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    task automatic load_state(input logic [31:0] ang, input logic [31:0] vel);
        send_item(OPC_LOAD, $urandom, $urandom, $urandom, ang, vel);
    endtask

    task automatic plan_step(input logic [31:0] tp, input logic [31:0] tv,
                             input logic [31:0] ta);
        send_item(~OPC_LOAD, tp, tv, ta, $urandom, $urandom);
    endtask

    // Drain all results before touching the registers.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_limits(input logic [31:0] amax, input logic [31:0] vmax,
                              input logic [31:0] wn, input logic [31:0] dt);
        write_reg(CFG_AMAX, amax);
        write_reg(CFG_VMAX, vmax);
        write_reg(CFG_WN, wn);
        write_reg(CFG_DT, dt);
    endtask

    // Random traffic: mostly a load followed by steps toward a nearby target.
    task automatic random_traffic(input int count);
        int stop, steps;
        logic [31:0] base, offs;
        stop = sent + count;
        while (sent < stop) begin
            if ($urandom_range(9) < 2) begin
                send_item(1'($urandom_range(1)), pick_value(), pick_value(), pick_value(),
                          pick_value(), pick_value());
            end else begin
                base = pick_value();
                load_state(base, pick_value());
                steps = $urandom_range(1, 6);
                repeat (steps) begin
                    offs = ($urandom_range(3) == 0) ? pick_value()
                         : 32'($signed($urandom_range(4096)) - 2048);
                    plan_step(base + offs,
                              ($urandom_range(1)) ? pick_value() : 32'd0,
                              ($urandom_range(2) == 0) ? pick_value() : 32'd0);
                end
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: loads at the extremes, each branch, zero error, saturation
        load_state(32'h7FFF_FFFF, 32'h8000_0000);
        load_state(32'h8000_0000, 32'h7FFF_FFFF);
        load_state(32'd0, 32'd0);
        plan_step(32'd0, 32'd0, 32'd0);                      // zero error, tracking
        plan_step(32'h0001_0000, 32'd0, 32'h0000_8000);      // tracking with feedforward
        load_state(32'd0, 32'h0008_0000);
        plan_step(32'h0000_0100, 32'd0, 32'd0);              // braking, saturated quotient
        load_state(32'd0, 32'h0000_4000);
        plan_step(32'h0000_2000, 32'h0000_1000, 32'd0);      // approaching, but tracking rather than braking
        load_state(32'd0, 32'hFFF0_0000);
        plan_step(32'h0100_0000, 32'd0, 32'd0);              // moving the wrong way
        load_state(32'h7FFF_0000, 32'h7FFF_FFFF);
        plan_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        load_state(32'h8000_0000, 32'h8000_0000);
        plan_step(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        plan_step(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        drain();

        // zero limits and zero time step
        set_limits(32'd0, 32'd0, 32'd0, 32'd0);
        load_state(32'h0001_0000, 32'h0002_0000);
        plan_step(32'h0004_0000, 32'd0, 32'h0001_0000);
        plan_step(32'h0001_0000, 32'd0, 32'd0);
        drain();

        // defaults, with a long receiver hold-off at the start
        set_limits(32'd1310720, 32'd655360, 32'd1310720, 32'd16777);
        hold_req = 3000;
        random_traffic(RANDOM_ITEMS / 5);
        drain();

        // largest settings, with no idling on either side
        set_limits(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF);
        calm = 1;
        random_traffic(RANDOM_ITEMS / 5);
        calm = 0;
        drain();

        // smallest nonzero limits and time step
        set_limits(32'd1, 32'd1, 32'd1, 32'd1);
        random_traffic(RANDOM_ITEMS / 5);
        drain();

        // random settings
        repeat (2) begin
            set_limits($urandom, $urandom, $urandom, 32'($urandom_range(1, 24'hFFFFFF)));
            random_traffic(RANDOM_ITEMS / 5);
            drain();
        end

        repeat (200) @(posedge i_clk);
        $display("sent %0d requests, checked %0d results", sent, checked);
        $display("branches seen: %0d tracking, %0d braking, %0d reversal",
                 tracks, brakes, reversals);
        if (errors == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results never returned", errors, pending);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// File: constrained_motion_planner.f
rtl/cmp_pkg.sv
rtl/cmp_div.sv
rtl/cmp_dp.sv
rtl/cmp_ctrl.sv
rtl/constrained_motion_planner.sv
dv/cmp_checker.sv
dv/tb_top.sv
